>>> src/bss_pkg.sv
// Shared constants, codes and the cell command type of the bounded sequence store.
package bss_pkg;

	// Default number of entries the sequence can hold.
	localparam int CAPACITY_DEF = 16;
	// Largest supported capacity; sets the width of the count carried to the cells.
	localparam int CAPACITY_MAX = 64;
	localparam int CNT_W = $clog2(CAPACITY_MAX + 1);

	// Field widths of a request and a result.
	localparam int OP_W = 2;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int STAT_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Status codes repeated on every result of a listing.
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// What every cell does in a cycle.
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_HOLD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_BACK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROTATE = 3'd4;

	// Command broadcast to the whole row of cells.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0] count;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} cell_cmd_t;

endpackage

>>> src/bounded_sequence_store_unit.sv
// Top level of the bounded sequence store: request decode, cell row and result listing.
//
// The block keeps up to CAPACITY signed 32-bit entries in a row of cells, front in cell 0.
// Each request inserts at the front, inserts at the back or deletes at a position; the
// change is made in the cycle the request is accepted. The whole sequence is then listed,
// one result per cycle unless m_tready holds the output, by rotating the occupied cells
// toward the front and reading cell 0; after a full turn the row is back in order. An empty
// list gives a single result. A new request is accepted as soon as the last result of the
// listing sits in the output register.
module bounded_sequence_store_unit
	import bss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// operation [1:0], value [33:2], position [41:34], zero fill [47:42]
	input logic [47:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// element [31:0]
	output logic [31:0] m_tdata,
	// element_valid [0], status [2:1]
	output logic [2:0] m_tuser,
	output logic m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_LIST = 1'b1;

	logic state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [STAT_W-1:0] status_q;
	logic m_valid_q;
	logic [VAL_W-1:0] elem_q;
	logic evalid_q;
	logic [STAT_W-1:0] out_status_q;
	logic last_q;

	logic [OP_W-1:0] req_op;
	logic [VAL_W-1:0] req_val;
	logic [POS_W-1:0] req_pos;
	logic accept;
	logic load;
	logic is_empty;
	logic is_last;
	logic [STAT_W-1:0] status_d;
	logic [CW-1:0] count_d;
	cell_cmd_t cmd;
	logic [VAL_W-1:0] cell_data [CAPACITY];

	assign req_op = s_tdata[1:0];
	assign req_val = s_tdata[33:2];
	assign req_pos = s_tdata[41:34];

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign load = (state_q == S_LIST) && (!m_valid_q || m_tready);
	assign is_empty = (count_q == '0);
	assign is_last = is_empty || ((idx_q + CW'(1)) == count_q);

	// Decode the request into a status, a new count and a command for the cells.
	always_comb begin
		status_d = STAT_DONE;
		count_d = count_q;
		cmd.mode = MODE_HOLD;
		cmd.count = CNT_W'(count_q);
		cmd.pos = req_pos;
		cmd.val = req_val;
		if (accept) begin
			case (req_op)
				OP_INS_FRONT, OP_INS_BACK: begin
					if (count_q == CAP_C) begin
						status_d = STAT_FULL;
					end else begin
						count_d = count_q + CW'(1);
						cmd.mode = (req_op == OP_INS_FRONT) ? MODE_INS_FRONT : MODE_INS_BACK;
					end
				end
				OP_DELETE: begin
					if (req_pos >= POS_W'(count_q)) begin
						status_d = STAT_RANGE;
					end else begin
						count_d = count_q - CW'(1);
						cmd.mode = MODE_DELETE;
					end
				end
				default: begin
					status_d = STAT_DONE;
				end
			endcase
		end else if (load && !is_empty) begin
			cmd.mode = MODE_ROTATE;
		end
	end

	// Row of cells holding the sequence.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_w;
		logic [VAL_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		bss_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.left_data(left_w),
			.right_data(right_w),
			.front_data(cell_data[0]),
			.data(cell_data[i])
		);
	end

	// Control: sequence count, listing position and request state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			status_q <= STAT_DONE;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				status_q <= status_d;
				idx_q <= '0;
				state_q <= S_LIST;
			end else if (load) begin
				if (is_last) begin
					idx_q <= '0;
					state_q <= S_IDLE;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output register with the front cell's entry.
	always_ff @(posedge clk) begin
		if (load) begin
			elem_q <= is_empty ? '0 : cell_data[0];
			evalid_q <= !is_empty;
			out_status_q <= status_q;
			last_q <= is_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = elem_q;
	assign m_tuser = {out_status_q, evalid_q};
	assign m_tlast = last_q;

endmodule

>>> src/bss_cell.sv
// One storage cell of the sequence row; it takes data from a neighbor, the front cell or the new value.
module bss_cell
	import bss_pkg::*;
#(
	parameter int IDX = 0
) (
	input logic clk,
	input cell_cmd_t cmd,
	input logic [VAL_W-1:0] left_data,
	input logic [VAL_W-1:0] right_data,
	input logic [VAL_W-1:0] front_data,
	output logic [VAL_W-1:0] data
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NXT_C = CNT_W'(IDX + 1);
	localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

	logic [VAL_W-1:0] entry_q;
	logic [VAL_W-1:0] entry_d;

	// Select the next content of this cell from the broadcast command.
	always_comb begin
		entry_d = entry_q;
		case (cmd.mode)
			MODE_INS_FRONT: begin
				if (IDX == 0) begin
					entry_d = cmd.val;
				end else if (IDX_C <= cmd.count) begin
					entry_d = left_data;
				end
			end
			MODE_INS_BACK: begin
				if (IDX_C == cmd.count) begin
					entry_d = cmd.val;
				end
			end
			MODE_DELETE: begin
				if (IDX_P >= cmd.pos && NXT_C < cmd.count) begin
					entry_d = right_data;
				end
			end
			MODE_ROTATE: begin
				if (NXT_C < cmd.count) begin
					entry_d = right_data;
				end else if (NXT_C == cmd.count) begin
					entry_d = front_data;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign data = entry_q;

endmodule

>>> sim/bounded_sequence_store_unit_tb.sv
// Self-checking testbench of the bounded sequence store: driver, listing monitor and predictor.
module bounded_sequence_store_unit_tb;
	import bss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = CAPACITY_DEF;
	localparam int RANDOM_REQUESTS = 93;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 250;
	localparam int HOLD_AFTER_RESULTS = 150;
	// The package names only three operations; the fourth code is a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
	} request_t;

	typedef struct {
		logic [VAL_W-1:0] element;
		logic valid;
		logic [STAT_W-1:0] status;
		logic last;
	} listing_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	request_t pending_reqs[$];
	request_t offered_req;
	listing_t expected_listing[$];
	logic [VAL_W-1:0] sequence_model[$];

	int errors;
	int cycles;
	int results_seen;
	int planned_count;
	int burst_left;
	int gap_left;
	int rx_mode;
	int hold_left;
	bit hold_done;

	bounded_sequence_store_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Queue a request and track how many entries the list will hold after it.
	task automatic queue_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		request_t r;
		r.op = op;
		r.val = val;
		r.pos = pos;
		pending_reqs.push_back(r);
		if ((op == OP_INS_FRONT || op == OP_INS_BACK) && planned_count < CAP)
			planned_count++;
		else if (op == OP_DELETE && pos < planned_count)
			planned_count--;
	endtask

	// Apply one accepted request to the shadow sequence and queue the listing it causes.
	function automatic void apply_sequence_op(input request_t r);
		logic [STAT_W-1:0] status;
		listing_t item;
		status = STAT_DONE;
		case (r.op)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (sequence_model.size() >= CAP)
					status = STAT_FULL;
				else if (r.op == OP_INS_FRONT)
					sequence_model.push_front(r.val);
				else
					sequence_model.push_back(r.val);
			end
			OP_DELETE: begin
				if (r.pos >= sequence_model.size())
					status = STAT_RANGE;
				else
					sequence_model.delete(r.pos);
			end
			default: begin
			end
		endcase
		if (sequence_model.size() == 0) begin
			item.element = '0;
			item.valid = 1'b0;
			item.status = status;
			item.last = 1'b1;
			expected_listing.push_back(item);
		end else begin
			foreach (sequence_model[i]) begin
				item.element = sequence_model[i];
				item.valid = 1'b1;
				item.status = status;
				item.last = (i == sequence_model.size() - 1);
				expected_listing.push_back(item);
			end
		end
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 4;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_sequence_op(offered_req);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					offered_req = pending_reqs.pop_front();
					s_tdata <= {6'b0, offered_req.pos, offered_req.val, offered_req.op};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: randomly chosen stall patterns, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (cycles % 50 == 0)
				rx_mode <= $urandom_range(0, 3);
			if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (cycles % 4 == 0);
					default: m_tready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// Listing monitor: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		listing_t want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_listing.size() == 0) begin
				$error("unexpected result: element %0d valid %0b status %0d last %0b",
					$signed(m_tdata), m_tuser[0], m_tuser[2:1], m_tlast);
				errors++;
			end else begin
				want = expected_listing.pop_front();
				if (m_tdata !== want.element) begin
					$error("element: expected %0d, got %0d", $signed(want.element),
						$signed(m_tdata));
					errors++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("element_valid: expected %0b, got %0b", want.valid, m_tuser[0]);
					errors++;
				end
				if (m_tuser[2:1] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		int r;
		int grow;
		bit timed_out;
		errors = 0;
		cycles = 0;
		results_seen = 0;
		planned_count = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;

		// Directed part: empty-list cases, extreme values, out-of-range deletes, full list.
		queue_request(OP_DELETE, 32'd0, 8'd0);
		queue_request(OP_UNUSED, 32'd0, 8'd0);
		queue_request(OP_INS_FRONT, 32'h8000_0000, 8'd0);
		queue_request(OP_INS_BACK, 32'h7fff_ffff, 8'd0);
		queue_request(OP_INS_FRONT, 32'hffff_ffff, 8'd0);
		queue_request(OP_INS_BACK, 32'd0, 8'd0);
		queue_request(OP_DELETE, 32'd0, 8'd255);
		queue_request(OP_DELETE, 32'd0, 8'(planned_count));
		queue_request(OP_DELETE, 32'd0, 8'd1);
		queue_request(OP_UNUSED, 32'hffff_ffff, 8'd255);
		while (planned_count < CAP)
			queue_request(planned_count[0] ? OP_INS_FRONT : OP_INS_BACK, $urandom, 8'd0);
		queue_request(OP_INS_FRONT, $urandom, 8'd0);
		queue_request(OP_INS_BACK, $urandom, 8'd0);
		queue_request(OP_DELETE, 32'd0, 8'(CAP - 1));
		queue_request(OP_DELETE, 32'd0, 8'd0);

		// Random part: growing and shrinking phases picked at random so the list swings
		// between empty and full.
		grow = 1;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 20 == 0)
				grow = $urandom_range(0, 1);
			r = $urandom_range(0, 99);
			if (r < (grow ? 35 : 15))
				queue_request(OP_INS_FRONT, $urandom, 8'($urandom));
			else if (r < (grow ? 70 : 30))
				queue_request(OP_INS_BACK, $urandom, 8'($urandom));
			else if (r < 92 && planned_count > 0)
				queue_request(OP_DELETE, $urandom,
					8'($urandom_range(0, planned_count - 1)));
			else if (r < 97)
				queue_request(OP_DELETE, $urandom, 8'($urandom_range(planned_count, 255)));
			else
				queue_request(OP_UNUSED, $urandom, 8'($urandom));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken and every listing to arrive.
		while ((pending_reqs.size() > 0 || s_tvalid || expected_listing.size() > 0)
				&& cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles >= CYCLE_LIMIT)
			timed_out = 1'b1;
		else
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out || expected_listing.size() > 0) begin
			$error("timeout with %0d results still expected", expected_listing.size());
			$display("** bounded_sequence_store_unit: FAILED **");
		end else if (errors == 0) begin
			$display("** bounded_sequence_store_unit: PASSED **");
		end else begin
			$display("** bounded_sequence_store_unit: FAILED **");
		end
		$finish;
	end

endmodule

>>> bounded_sequence_store_unit.f
src/bss_pkg.sv
src/bss_cell.sv
src/bounded_sequence_store_unit.sv
sim/bounded_sequence_store_unit_tb.sv
